// File: rtl/core/kmer_shannon_entropy_defines.svh
// Assertion macros for the kmer entropy RTL
`ifndef KMER_SHANNON_ENTROPY_DEFINES_SVH
`define KMER_SHANNON_ENTROPY_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define KSE_ASSERT_SAME(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("kse: same-cycle check failed");

// Check that cons holds in the cycle after ante
`define KSE_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("kse: next-cycle check failed");

`endif

// File: rtl/core/kse_pkg.sv
// Shared constants, types and the log2 table builder for the kmer entropy block
`timescale 1ns / 1ps
`default_nettype none

package kse_pkg;

    // Field and register widths
    localparam int unsigned KMER_BITS  = 64;
    localparam int unsigned LEN_W      = 6;
    localparam int unsigned CNT_W      = 6;
    localparam int unsigned OUT_W      = 16;
    localparam int unsigned NUM_CODES  = 4;
    localparam int unsigned GRP_BASES  = 8;
    localparam int unsigned GCNT_W     = 4;

    // Log arithmetic: 30 fraction bits, integer part up to 5
    localparam int unsigned LOG_FRAC   = 30;
    localparam int unsigned LOG_W      = LOG_FRAC + 3;
    localparam int unsigned SUM_W      = LOG_FRAC + 7;
    localparam int unsigned LOG_TAB_N  = 64;

    // Parameter defaults
    localparam int unsigned DEF_MAX_KMER_BASES    = 32;
    localparam int unsigned DEF_ENTROPY_FRAC_BITS = 14;

    // Configuration port
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic        REG_BASE_LEN   = 1'b0;
    localparam logic [LEN_W-1:0] BASE_LEN_RESET = 6'd25;

    typedef logic [LOG_TAB_N-1:0][LOG_W-1:0] log_tab_t;
    typedef logic [NUM_CODES-1:0][CNT_W-1:0] code_cnt_t;

    // Beat from the base counter to the log stage
    typedef struct packed {
        logic [LEN_W-1:0] len;
        code_cnt_t        cnt;
    } cnt_beat_t;

    // Width of the scaled numerator fed to the divider
    function automatic int unsigned num_width(input int unsigned frac_bits);
        int unsigned w;
        w = SUM_W + 1 - (LOG_FRAC - frac_bits);
        return (w > OUT_W) ? w : OUT_W + 1;
    endfunction

    // log2(n) by repeated squaring; evaluated at elaboration only
    function automatic logic [LOG_W-1:0] log2_fixed(input int unsigned n);
        logic [63:0]         x;
        logic [LOG_FRAC-1:0] frac;
        int unsigned         ip;
        ip = 0;
        while (ip < 6 && (n >> (ip + 1)) != 0)
            ip++;
        x = (64'(n) << LOG_FRAC) >> ip;
        frac = '0;
        for (int b = 0; b < LOG_FRAC; b++)
        begin
            x = (x * x) >> LOG_FRAC;
            frac = {frac[LOG_FRAC-2:0], 1'b0};
            if (x >= (64'd2 << LOG_FRAC))
            begin
                x = x >> 1;
                frac[0] = 1'b1;
            end
        end
        return {3'(ip), frac};
    endfunction

    // Table of log2 for 0..63, entry 0 reads as zero
    function automatic log_tab_t build_log_tab();
        log_tab_t t;
        for (int n = 0; n < LOG_TAB_N; n++)
        begin
            t[n] = log2_fixed(n);
        end
        return t;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/kse_cfg.sv
// APB register holding the k-mer length
`timescale 1ns / 1ps
`default_nettype none

module kse_cfg (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [kse_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [kse_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [kse_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready,
    output logic      [kse_pkg::LEN_W-1:0]       base_len
);
    import kse_pkg::*;

    logic             wr_hit;
    logic [LEN_W-1:0] base_len_reg;
    logic [LEN_W-1:0] base_len_next;

    // Decode a write beat to the length register
    assign wr_hit = psel && penable && pwrite && pready
                    && (paddr[APB_ADDR_W-1] == REG_BASE_LEN);

    always_comb
    begin
        base_len_next = base_len_reg;
        if (wr_hit)
        begin
            base_len_next = pwdata[LEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_len_reg <= BASE_LEN_RESET;
        end
        else
        begin
            base_len_reg <= base_len_next;
        end
    end

    // Read back
    always_comb
    begin
        prdata = '0;
        if (paddr[APB_ADDR_W-1] == REG_BASE_LEN)
        begin
            prdata = APB_DATA_W'(base_len_reg);
        end
    end

    assign pready   = 1'b1;
    assign base_len = base_len_reg;

endmodule

`default_nettype wire

// File: rtl/core/kse_count.sv
// Two-stage base counter: per-group counts, then per-code totals
`timescale 1ns / 1ps
`default_nettype none

module kse_count #(
    parameter int unsigned MAX_KMER_BASES = kse_pkg::DEF_MAX_KMER_BASES
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [kse_pkg::LEN_W-1:0]     base_len,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [kse_pkg::KMER_BITS-1:0] kmer_value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output kse_pkg::cnt_beat_t                 out_beat
);
    import kse_pkg::*;

    localparam int unsigned NG = (MAX_KMER_BASES + GRP_BASES - 1) / GRP_BASES;
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_KMER_BASES);

    logic [LEN_W-1:0] len_sat;
    logic [NG-1:0][NUM_CODES-1:0][GCNT_W-1:0] gcnt_next;
    logic [NG-1:0][NUM_CODES-1:0][GCNT_W-1:0] s1_gcnt_reg;
    logic [LEN_W-1:0] s1_len_reg;
    logic             s1_valid_reg;
    logic             s1_rdy;
    code_cnt_t        cnt_next;
    cnt_beat_t        s2_beat_reg;
    logic             s2_valid_reg;
    logic             s2_rdy;

    // Saturate the length at the supported maximum
    assign len_sat = (base_len > MAX_LEN) ? MAX_LEN : base_len;

    // Count each code within groups of eight bases
    always_comb
    begin
        gcnt_next = '0;
        for (int g = 0; g < NG; g++)
        begin
            for (int j = 0; j < GRP_BASES; j++)
            begin
                if ((g * GRP_BASES + j) < int'(len_sat))
                begin
                    gcnt_next[g][kmer_value[2*(g*GRP_BASES+j) +: 2]] =
                        gcnt_next[g][kmer_value[2*(g*GRP_BASES+j) +: 2]] + GCNT_W'(1);
                end
            end
        end
    end

    // Add the group counts per code
    always_comb
    begin
        cnt_next = '0;
        for (int k = 0; k < NUM_CODES; k++)
        begin
            for (int g = 0; g < NG; g++)
            begin
                cnt_next[k] = cnt_next[k] + CNT_W'(s1_gcnt_reg[g][k]);
            end
        end
    end

    // Stage readiness: a stage loads when empty or when its successor moves
    assign s2_rdy   = !s2_valid_reg || out_ready;
    assign s1_rdy   = !s1_valid_reg || s2_rdy;
    assign in_ready = s1_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_rdy)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_rdy)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_rdy && in_valid)
        begin
            s1_gcnt_reg <= gcnt_next;
            s1_len_reg  <= len_sat;
        end
        if (s2_rdy && s1_valid_reg)
        begin
            s2_beat_reg.len <= s1_len_reg;
            s2_beat_reg.cnt <= cnt_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_beat  = s2_beat_reg;

endmodule

`default_nettype wire

// File: rtl/core/kse_logmul.sv
// Log lookup, weighting by count and summation into the scaled numerator
`timescale 1ns / 1ps
`default_nettype none

module kse_logmul #(
    parameter int unsigned ENTROPY_FRAC_BITS = kse_pkg::DEF_ENTROPY_FRAC_BITS,
    parameter int unsigned NUM_W = kse_pkg::num_width(ENTROPY_FRAC_BITS)
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire kse_pkg::cnt_beat_t        in_beat,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [NUM_W-1:0]               out_num,
    output logic [kse_pkg::LEN_W-1:0]      out_div
);
    import kse_pkg::*;

    localparam int unsigned SHIFT = LOG_FRAC - ENTROPY_FRAC_BITS;
    localparam log_tab_t    LOG_TAB = build_log_tab();

    logic [NUM_CODES-1:0][LOG_W-1:0] diff_next;
    logic [NUM_CODES-1:0][LOG_W-1:0] s3_diff_reg;
    code_cnt_t                       s3_cnt_reg;
    logic [LEN_W-1:0]                s3_len_reg;
    logic                            s3_valid_reg;
    logic                            s3_rdy;

    logic [NUM_CODES-1:0][CNT_W+LOG_W-1:0] prod_full;
    logic [NUM_CODES-1:0][SUM_W-1:0]       s4_prod_reg;
    logic [LEN_W-1:0]                      s4_len_reg;
    logic                                  s4_valid_reg;
    logic                                  s4_rdy;

    logic [SUM_W-1:0] sum_next;
    logic [NUM_W-1:0] num_next;
    logic [LEN_W-1:0] div_next;
    logic [NUM_W-1:0] s5_num_reg;
    logic [LEN_W-1:0] s5_div_reg;
    logic             s5_valid_reg;
    logic             s5_rdy;

    // log2(L) - log2(c) per code; a zero count is cancelled by its weight later
    always_comb
    begin
        for (int k = 0; k < NUM_CODES; k++)
        begin
            diff_next[k] = LOG_TAB[in_beat.len] - LOG_TAB[in_beat.cnt[k]];
        end
    end

    // Weight each difference by its count
    always_comb
    begin
        for (int k = 0; k < NUM_CODES; k++)
        begin
            prod_full[k] = s3_cnt_reg[k] * s3_diff_reg[k];
        end
    end

    // Sum, add half a divisor for rounding, drop the low bits below the divisor scale
    always_comb
    begin
        sum_next = (SUM_W'(s4_len_reg) << (SHIFT - 1));
        for (int k = 0; k < NUM_CODES; k++)
        begin
            sum_next = sum_next + s4_prod_reg[k];
        end
        num_next = NUM_W'(sum_next >> SHIFT);
        div_next = (s4_len_reg == '0) ? LEN_W'(1) : s4_len_reg;
    end

    assign s5_rdy   = !s5_valid_reg || out_ready;
    assign s4_rdy   = !s4_valid_reg || s5_rdy;
    assign s3_rdy   = !s3_valid_reg || s4_rdy;
    assign in_ready = s3_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (s3_rdy)
            begin
                s3_valid_reg <= in_valid;
            end
            if (s4_rdy)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (s5_rdy)
            begin
                s5_valid_reg <= s4_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_rdy && in_valid)
        begin
            s3_diff_reg <= diff_next;
            s3_cnt_reg  <= in_beat.cnt;
            s3_len_reg  <= in_beat.len;
        end
        if (s4_rdy && s3_valid_reg)
        begin
            for (int k = 0; k < NUM_CODES; k++)
            begin
                s4_prod_reg[k] <= SUM_W'(prod_full[k]);
            end
            s4_len_reg <= s3_len_reg;
        end
        if (s5_rdy && s4_valid_reg)
        begin
            s5_num_reg <= num_next;
            s5_div_reg <= div_next;
        end
    end

    assign out_valid = s5_valid_reg;
    assign out_num   = s5_num_reg;
    assign out_div   = s5_div_reg;

endmodule

`default_nettype wire

// File: rtl/core/kse_div.sv
// Pipelined restoring divider, one quotient bit per stage, with saturating output register
`timescale 1ns / 1ps
`default_nettype none

module kse_div #(
    parameter int unsigned ENTROPY_FRAC_BITS = kse_pkg::DEF_ENTROPY_FRAC_BITS,
    parameter int unsigned NUM_W = kse_pkg::num_width(ENTROPY_FRAC_BITS)
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [NUM_W-1:0]          in_num,
    input  wire logic [kse_pkg::LEN_W-1:0] in_div,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [kse_pkg::OUT_W-1:0]      entropy_fixed
);
    import kse_pkg::*;

    logic             v_reg   [NUM_W];
    logic [NUM_W-1:0] rq_reg  [NUM_W];
    logic [LEN_W-1:0] rem_reg [NUM_W];
    logic [LEN_W-1:0] div_reg [NUM_W];
    logic [NUM_W-1:0] rq_next [NUM_W];
    logic [LEN_W-1:0] rem_next[NUM_W];
    logic [NUM_W:0]   stg_rdy;

    logic             out_valid_reg;
    logic [OUT_W-1:0] entropy_fixed_reg;
    logic [OUT_W-1:0] entropy_fixed_next;

    // One shift-compare-subtract step per stage; quotient bits shift in from the bottom
    for (genvar k = 0; k < NUM_W; k++)
    begin : g_stage
        logic             v_in;
        logic [NUM_W-1:0] rq_in;
        logic [LEN_W-1:0] rem_in;
        logic [LEN_W-1:0] div_in;
        logic [LEN_W:0]   trial;
        logic             take;

        if (k == 0)
        begin : g_first
            assign v_in   = in_valid;
            assign rq_in  = in_num;
            assign rem_in = '0;
            assign div_in = in_div;
        end
        else
        begin : g_rest
            assign v_in   = v_reg[k-1];
            assign rq_in  = rq_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign div_in = div_reg[k-1];
        end

        assign trial       = {rem_in, rq_in[NUM_W-1]};
        assign take        = (trial >= {1'b0, div_in});
        assign rq_next[k]  = {rq_in[NUM_W-2:0], take};
        assign rem_next[k] = take ? LEN_W'(trial - {1'b0, div_in}) : LEN_W'(trial);
        assign stg_rdy[k]  = !v_reg[k] || stg_rdy[k+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (stg_rdy[k])
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (stg_rdy[k] && v_in)
            begin
                rq_reg[k]  <= rq_next[k];
                rem_reg[k] <= rem_next[k];
                div_reg[k] <= div_in;
            end
        end
    end

    // Clamp an oversized quotient to all ones
    assign entropy_fixed_next = (|rq_reg[NUM_W-1][NUM_W-1:OUT_W])
                                ? '1 : rq_reg[NUM_W-1][OUT_W-1:0];
    assign stg_rdy[NUM_W] = !out_valid_reg || out_ready;
    assign in_ready       = stg_rdy[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stg_rdy[NUM_W])
        begin
            out_valid_reg <= v_reg[NUM_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stg_rdy[NUM_W] && v_reg[NUM_W-1])
        begin
            entropy_fixed_reg <= entropy_fixed_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign entropy_fixed = entropy_fixed_reg;

endmodule

`default_nettype wire

// File: rtl/core/kmer_shannon_entropy.sv
// Top level of the k-mer Shannon entropy pipeline
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------
//  apb     | in        | psel/penable, pready=1 | paddr, pwdata, prdata
//  kmer    | in        | in_valid/in_ready      | kmer_value[63:0]
//  entropy | out       | out_valid/out_ready    | entropy_fixed[15:0]
//
// One beat enters per cycle while in_ready is high. The pipeline has two count stages,
// three log/weight/sum stages, W = max(8 + ENTROPY_FRAC_BITS, 17) divider stages of one
// quotient bit each and the output register.
// Reset clears every valid bit and sets the length register to 25; payload registers
// are not reset.
// Each stage loads when empty or when the stage after it moves, so bubbles close up
// and a held result stalls only the stages behind it.
`timescale 1ns / 1ps
`default_nettype none
`include "kmer_shannon_entropy_defines.svh"

module kmer_shannon_entropy #(
    parameter int unsigned MAX_KMER_BASES    = kse_pkg::DEF_MAX_KMER_BASES,
    parameter int unsigned ENTROPY_FRAC_BITS = kse_pkg::DEF_ENTROPY_FRAC_BITS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [kse_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [kse_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [kse_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                 pready,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [kse_pkg::KMER_BITS-1:0]   kmer_value,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic      [kse_pkg::OUT_W-1:0]       entropy_fixed
);
    import kse_pkg::*;

    localparam int unsigned NUM_W = num_width(ENTROPY_FRAC_BITS);

    logic [LEN_W-1:0] base_len;
    logic             cnt_valid;
    logic             cnt_ready;
    cnt_beat_t        cnt_beat;
    logic             num_valid;
    logic             num_ready;
    logic [NUM_W-1:0] num_value;
    logic [LEN_W-1:0] num_div;

    // Configuration register
    kse_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .base_len (base_len)
    );

    // Base counting
    kse_count #(
        .MAX_KMER_BASES (MAX_KMER_BASES)
    ) u_count (
        .clk         (clk),
        .rst_n       (rst_n),
        .base_len    (base_len),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kmer_value  (kmer_value),
        .out_valid   (cnt_valid),
        .out_ready   (cnt_ready),
        .out_beat    (cnt_beat)
    );

    // Weighted log sum
    kse_logmul #(
        .ENTROPY_FRAC_BITS (ENTROPY_FRAC_BITS),
        .NUM_W             (NUM_W)
    ) u_logmul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cnt_valid),
        .in_ready  (cnt_ready),
        .in_beat   (cnt_beat),
        .out_valid (num_valid),
        .out_ready (num_ready),
        .out_num   (num_value),
        .out_div   (num_div)
    );

    // Division by the length and output register
    kse_div #(
        .ENTROPY_FRAC_BITS (ENTROPY_FRAC_BITS),
        .NUM_W             (NUM_W)
    ) u_div (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (num_valid),
        .in_ready      (num_ready),
        .in_num        (num_value),
        .in_div        (num_div),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .entropy_fixed (entropy_fixed)
    );

    // A taken result frees every stage, so the input side must be open
    `KSE_ASSERT_SAME(a_ready_chain, clk, rst_n, out_ready, in_ready)

    // A write beat to the length register lands in the next cycle
    `KSE_ASSERT_NEXT(a_len_write, clk, rst_n,
        psel && penable && pwrite && pready && (paddr[APB_ADDR_W-1] == REG_BASE_LEN),
        base_len == $past(pwdata[LEN_W-1:0]))

endmodule

`default_nettype wire
